// File: sv/flp_pkg.sv
// shared types, constants and coefficient table for the 31-tap low-pass fir
`timescale 1ns / 1ps

package flp_pkg;

    // field and datapath widths
    localparam int TAPS        = 31;
    localparam int TAP_IDX_W   = $clog2(TAPS);
    localparam int MICRO_SCALE = 1000000;
    localparam int IN_INT_W    = 13;
    localparam int IN_MICRO_W  = 21;
    localparam int SAMPLE_W    = 32;
    localparam int COEF_W      = 24;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 64;
    localparam int VALUE_W     = 34;
    localparam int FILT_W      = 34;

    // coefficient scaling; the filtered magnitude then stays below 2^32
    localparam int FRACTION_BITS = 16;

    // divide by one million: magnitude times a scaled reciprocal
    localparam int MAG_W        = 32;
    localparam int RECIP_SHIFT  = 50;
    localparam int RECIP_PROD_W = 2 * MAG_W;
    localparam int QUOT_W       = RECIP_PROD_W - RECIP_SHIFT;
    localparam int DIV_STEPS    = 4;

    typedef logic signed [IN_INT_W-1:0]   t_int_part;
    typedef logic signed [IN_MICRO_W-1:0] t_micro_part;
    typedef logic signed [SAMPLE_W-1:0]   t_sample;
    typedef logic signed [COEF_W-1:0]     t_coef;
    typedef t_coef                        t_coef_tab [TAPS];
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;
    typedef logic signed [VALUE_W-1:0]    t_value;
    typedef logic signed [FILT_W-1:0]     t_filt;
    typedef logic [TAP_IDX_W-1:0]         t_tap_idx;
    typedef logic [MAG_W-1:0]             t_mag;
    typedef logic [RECIP_PROD_W-1:0]      t_rprod;
    typedef logic [QUOT_W-1:0]            t_quot;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctl;

    localparam t_tap_idx TAP_LAST  = t_tap_idx'(TAPS - 1);
    localparam t_value   SCALE_VAL = t_value'(MICRO_SCALE);
    localparam t_sample  SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample  SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // ceil(2^50 / 1000000); the rounding error is small enough for any 32-bit magnitude
    localparam t_mag RECIP_MICRO = t_mag'(((longint'(1) << RECIP_SHIFT)
        + longint'(MICRO_SCALE) - 1) / longint'(MICRO_SCALE));
    localparam t_mag MICRO_MAG   = t_mag'(MICRO_SCALE);

    // symmetric low-pass tap weights in millionths
    localparam int TAP_MILLIONTHS [TAPS] = '{
        -648, -1444, -2702, -4441, -6191, -6959, -5371, 0,
        10207, 25522, 45170, 67289, 89180, 107781, 120271, 124672,
        120271, 107781, 89180, 67289, 45170, 25522, 10207, 0,
        -5371, -6959, -6191, -4441, -2702, -1444, -648
    };

    // weight scaled by 2^fb, truncated toward zero
    function automatic t_coef scale_coef(input int millionths, input int fb);
        longint mag;
        longint q;
        mag = (millionths < 0) ? -longint'(millionths) : longint'(millionths);
        q   = (mag << fb) / MICRO_SCALE;
        if (millionths < 0) begin
            q = -q;
        end
        return t_coef'(q);
    endfunction

    // whole coefficient rom for a given fraction width
    function automatic t_coef_tab coef_table(input int fb);
        t_coef_tab tab;
        for (int k = 0; k < TAPS; k++) begin
            tab[k] = scale_coef(TAP_MILLIONTHS[k], fb);
        end
        return tab;
    endfunction

endpackage

// File: sv/flp_ifs.sv
// valid/ready channel interfaces for samples in and filtered results out
`timescale 1ns / 1ps

interface flp_in_if;
    import flp_pkg::*;

    logic        valid;
    logic        ready;
    t_int_part   integer_part;
    t_micro_part micro_part;

    modport source (output valid, output integer_part, output micro_part, input ready);
    modport sink   (input valid, input integer_part, input micro_part, output ready);
endinterface

interface flp_out_if;
    import flp_pkg::*;

    logic        valid;
    logic        ready;
    t_int_part   out_integer_part;
    t_micro_part out_micro_part;

    modport source (output valid, output out_integer_part, output out_micro_part,
                    input ready);
    modport sink   (input valid, input out_integer_part, input out_micro_part,
                    output ready);
endinterface

// File: sv/flp_mac.sv
// shared multiply-accumulate unit, one tap per cycle with a registered product
`timescale 1ns / 1ps

module flp_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  flp_pkg::t_mac_ctl i_ctl,
    input  flp_pkg::t_sample  i_sample,
    input  flp_pkg::t_coef    i_coef,
    output flp_pkg::t_acc     o_acc
);
    import flp_pkg::*;

    t_prod r_prod;
    logic  r_prod_vld;
    t_acc  r_acc;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_sample) * t_prod'(i_coef);
        if (!i_rst_n || i_ctl.clr) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.en;
        end
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// File: sv/flp_div.sv
// divider by one million through a reciprocal multiply, truncating toward zero
`timescale 1ns / 1ps

module flp_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  flp_pkg::t_filt       i_dividend,
    output logic                 o_done,
    output flp_pkg::t_int_part   o_quot,
    output flp_pkg::t_micro_part o_rem
);
    import flp_pkg::*;

    logic [DIV_STEPS-1:0]  r_step;
    logic                  r_done;
    logic                  r_neg;
    t_mag                  r_mag;
    t_rprod                r_prod;
    t_quot                 r_quot;
    t_mag                  r_qm;
    logic [IN_MICRO_W-1:0] r_rem;
    t_filt                 w_abs;
    t_mag                  w_diff;
    logic [IN_INT_W-1:0]   w_q_lo;
    logic [IN_MICRO_W-1:0] w_r_lo;

    assign w_abs  = i_dividend[FILT_W-1] ? -i_dividend : i_dividend;
    assign w_diff = r_mag - r_qm;

    // one marker bit walks through the steps; done holds until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_step <= {r_step[DIV_STEPS-2:0], i_start};
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_step[DIV_STEPS-1]) begin
                r_done <= 1'b1;
            end
        end
    end

    // magnitude, reciprocal multiply, quotient, back-multiply, remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[FILT_W-1];
            r_mag <= w_abs[MAG_W-1:0];
        end
        if (r_step[0]) begin
            r_prod <= t_rprod'(r_mag) * t_rprod'(RECIP_MICRO);
        end
        if (r_step[1]) begin
            r_quot <= r_prod[RECIP_PROD_W-1:RECIP_SHIFT];
        end
        if (r_step[2]) begin
            r_qm <= t_mag'(r_quot) * MICRO_MAG;
        end
        if (r_step[DIV_STEPS-1]) begin
            r_rem <= w_diff[IN_MICRO_W-1:0];
        end
    end

    // restore the sign of the dividend on both parts
    assign w_q_lo = r_quot[IN_INT_W-1:0];
    assign w_r_lo = r_rem;
    assign o_quot = t_int_part'(r_neg ? -w_q_lo : w_q_lo);
    assign o_rem  = t_micro_part'(r_neg ? -w_r_lo : w_r_lo);
    assign o_done = r_done;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (t_mag'(r_rem) < MICRO_MAG))
        else $error("divider remainder not below one million");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_step == '0))
        else $error("divider started while busy");

    a_step_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_step))
        else $error("divider step marker not single");

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_step == '0))
        else $error("divider busy and done together");

endmodule

// File: sv/fir_lowpass_31tap.sv
// top level: 31-tap low-pass fir on sensor readings with a shared mac and reciprocal divide
// usage
//   i_in carries one reading as a signed whole part and a signed millionths part;
//   o_out carries the filtered reading split the same way. both are valid/ready
//   channels and a transfer happens when valid and ready are high at a clock edge.
//   the reading is combined to whole*1000000 + millionths, saturated to 32 bits,
//   and pushed into a 31-sample delay line; one multiplier then walks the taps.
// sequence
//   after a transfer on i_in the block works in order: combine and shift, the mac
//   walk over the taps (one at a time, through the single shared multiplier),
//   a drain of the mac pipeline and the start of the divide, and the divide by
//   one million (reciprocal multiply, quotient select, back-multiply, remainder
//   subtract, output load). i_in.ready is high only while the block is idle,
//   so a new reading is taken only once the last result is in the output register.
// reset
//   i_rst_n is synchronous active low; it clears the delay line to zeros,
//   empties the output register and returns the sequencer to idle.
// stalls
//   the result sits in an output register; a new reading is accepted while it
//   waits, and the next result is held in the divider until o_out is taken.
`timescale 1ns / 1ps

module fir_lowpass_31tap (
    input  logic             i_clk,
    input  logic             i_rst_n,
    flp_in_if.sink           i_in,
    flp_out_if.source        o_out
);
    import flp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_COMB  = 6'b000010,
        S_MAC   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_DIVS  = 6'b010000,
        S_DIV   = 6'b100000
    } t_state;

    localparam t_coef_tab COEF_ROM = coef_table(FRACTION_BITS);

    t_state      r_state, n_state;
    t_tap_idx    r_idx, n_idx;
    t_int_part   r_int_part;
    t_micro_part r_micro_part;
    t_sample     r_taps [TAPS];
    logic        r_out_valid;
    t_int_part   r_out_int;
    t_micro_part r_out_micro;

    t_value      w_value;
    t_sample     w_sample;
    logic        w_sat_hi;
    logic        w_sat_lo;
    t_mac_ctl    w_mac_ctl;
    t_acc        w_acc;
    t_acc        w_acc_shr;
    logic        w_div_start;
    logic        w_div_done;
    t_int_part   w_quot;
    t_micro_part w_rem;
    logic        w_load_out;
    logic        w_in_xfer;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // combine whole and millionths parts, saturate to 32 bits
    assign w_value  = t_value'(r_int_part) * SCALE_VAL + t_value'(r_micro_part);
    assign w_sat_hi = !w_value[VALUE_W-1] && (|w_value[VALUE_W-2:SAMPLE_W-1]);
    assign w_sat_lo = w_value[VALUE_W-1] && !(&w_value[VALUE_W-2:SAMPLE_W-1]);
    assign w_sample = w_sat_hi ? SAMPLE_MAX :
                      w_sat_lo ? SAMPLE_MIN : w_value[SAMPLE_W-1:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        w_mac_ctl   = '0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                w_mac_ctl.clr = 1'b1;
                n_idx         = '0;
                n_state       = S_MAC;
            end
            S_MAC: begin
                w_mac_ctl.en = 1'b1;
                if (r_idx == TAP_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + t_tap_idx'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DIVS;
            end
            S_DIVS: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done && (!r_out_valid || o_out.ready)) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_int_part   <= i_in.integer_part;
            r_micro_part <= i_in.micro_part;
        end
    end

    // delay line, newest sample at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_taps[k] <= '0;
            end
        end else if (r_state == S_COMB) begin
            r_taps[0] <= w_sample;
            for (int k = 1; k < TAPS; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
        end
    end

    flp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_sample (r_taps[r_idx]),
        .i_coef   (COEF_ROM[r_idx]),
        .o_acc    (w_acc)
    );

    // arithmetic shift rounds toward minus infinity
    assign w_acc_shr = w_acc >>> FRACTION_BITS;

    flp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_acc_shr[FILT_W-1:0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_int   <= w_quot;
            r_out_micro <= w_rem;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.out_integer_part = r_out_int;
    assign o_out.out_micro_part   = r_out_micro;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_idx <= TAP_LAST))
        else $error("tap index out of range");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_COMB))
        else $error("accepted reading not processed");

    a_result_from_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_div_done))
        else $error("result shown without a finished divide");

endmodule

// File: dv/testbench.sv
// self-checking testbench for the 31-tap low-pass fir on sensor readings
`timescale 1ns / 1ps

module testbench;
    import flp_pkg::*;

    localparam int     FB            = FRACTION_BITS;
    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     SETTLE_CYCLES = 60;
    localparam int     HOLD_CYCLES   = 500;
    localparam int     RANDOM_ITEMS  = 600;
    localparam int     IDLE_PCT      = 26;
    localparam longint SCALE         = 1000000;
    localparam longint VALUE_MAX     = longint'(SAMPLE_MAX);
    localparam longint VALUE_MIN     = longint'(SAMPLE_MIN);

    // tap weights in millionths, kept apart from the design's own table
    localparam int WEIGHT_MILLIONTHS [TAPS] = '{
        -648, -1444, -2702, -4441, -6191, -6959, -5371, 0,
        10207, 25522, 45170, 67289, 89180, 107781, 120271, 124672,
        120271, 107781, 89180, 67289, 45170, 25522, 10207, 0,
        -5371, -6959, -6191, -4441, -2702, -1444, -648
    };

    typedef enum {
        MODE_SENSOR,
        MODE_RAW,
        MODE_RAIL,
        MODE_WORST_CASE,
        MODE_NEAR_ZERO
    } t_stim_mode;

    typedef struct packed {
        t_int_part   whole;
        t_micro_part micro;
    } t_split_reading;

    logic i_clk;
    logic i_rst_n;

    flp_in_if  in_if ();
    flp_out_if out_if ();

    fir_lowpass_31tap dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_sample        sample_hist [TAPS];
    t_coef          tap_coef [TAPS];
    t_split_reading filtered_q [$];
    int             err_count   = 0;
    int             cycle_count = 0;
    bit             idling_on   = 1'b1;
    int             hold_request = 0;
    int             hold_taken   = 0;
    int             hold_left    = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // weight scaled by 2^fb, truncated toward zero
    function automatic t_coef fixed_weight(input int millionths);
        longint mag;
        longint q;
        mag = (millionths < 0) ? -longint'(millionths) : longint'(millionths);
        q   = (mag << FB) / SCALE;
        return t_coef'((millionths < 0) ? -q : q);
    endfunction

    // combine, shift into the delay line, convolve and split one reading
    function automatic void predict_filtered(input t_int_part whole, input t_micro_part micro);
        longint         value;
        longint         acc;
        longint         filt;
        t_split_reading res;
        value = longint'(whole) * SCALE + longint'(micro);
        if (value > VALUE_MAX) begin
            value = VALUE_MAX;
        end else if (value < VALUE_MIN) begin
            value = VALUE_MIN;
        end
        for (int k = TAPS - 1; k > 0; k--) begin
            sample_hist[k] = sample_hist[k-1];
        end
        sample_hist[0] = t_sample'(value);
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(sample_hist[k]) * longint'(tap_coef[k]);
        end
        // arithmetic shift rounds toward minus infinity
        filt      = acc >>> FB;
        res.whole = t_int_part'(filt / SCALE);
        res.micro = t_micro_part'(filt % SCALE);
        filtered_q.push_back(res);
    endfunction

    // offer one reading, with an occasional gap first, and wait for its transfer
    task automatic send_reading(input int whole, input int micro);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, 70);
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.integer_part <= t_int_part'(whole);
        in_if.micro_part   <= t_micro_part'(micro);
        do @(posedge i_clk); while (!in_if.ready);
        predict_filtered(t_int_part'(whole), t_micro_part'(micro));
    endtask

    // lower valid and move to the falling edge to change shared controls
    task automatic release_input();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input bit on);
        release_input();
        idling_on = on;
        @(posedge i_clk);
    endtask

    // hold the input low until every expected result has arrived
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (filtered_q.size() != 0);
    endtask

    // extremes of both fields, saturation edges, mixed signs, impulse tail
    task automatic test_directed_readings();
        int dir_whole [25] = '{
            0, 0, 0, 2147, 2147, -2147, -2147, 4095, -4096, 2147,
            -2147, 2147, -2147, 0, 0, 4095, -4096, 1, -1, 0,
            0, 0, 0, 0, 0
        };
        int dir_micro [25] = '{
            0, 1, -1, 483647, 483648, -483648, -483649, 1048575, -1048576, 999999,
            -999999, -999999, 999999, 1048575, -1048576, 0, 0, 0, 0, 0,
            0, 0, 0, 0, 0
        };
        for (int i = 0; i < 25; i++) begin
            send_reading(dir_whole[i], dir_micro[i]);
        end
        wait_for_results();
    endtask

    // segments of sensor-like, raw, rail, worst-case and near-zero readings
    task automatic test_random_readings();
        int         sent;
        int         len;
        int         whole;
        int         micro;
        int         rail;
        int         pick;
        bit         neg;
        bit         quiet_started;
        bit         quiet_done;
        t_stim_mode mode;
        sent          = 0;
        quiet_started = 1'b0;
        quiet_done    = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            // one stretch without any idling on either side
            if (!quiet_started && sent >= 200) begin
                set_idling(1'b0);
                quiet_started = 1'b1;
            end else if (quiet_started && !quiet_done && sent >= 330) begin
                set_idling(1'b1);
                quiet_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                mode = MODE_SENSOR;
            end else if (pick < 70) begin
                mode = MODE_RAW;
            end else if (pick < 80) begin
                mode = MODE_RAIL;
            end else if (pick < 87) begin
                mode = MODE_WORST_CASE;
            end else begin
                mode = MODE_NEAR_ZERO;
            end
            len  = (mode == MODE_RAIL) ? $urandom_range(31, 40) :
                   (mode == MODE_WORST_CASE) ? TAPS : $urandom_range(1, 30);
            rail = $urandom_range(3);
            neg  = 1'($urandom_range(1));
            for (int i = 0; i < len; i++) begin
                case (mode)
                    MODE_SENSOR: begin
                        whole = $urandom_range(0, 2147);
                        micro = $urandom_range(0, 999999);
                        if ($urandom_range(1)) begin
                            whole = -whole;
                            micro = -micro;
                        end
                    end
                    MODE_RAW: begin
                        whole = int'($urandom_range(0, 8191)) - 4096;
                        micro = int'($urandom_range(0, 2097151)) - 1048576;
                    end
                    MODE_RAIL: begin
                        case (rail)
                            0: begin whole = 2147;  micro = 483647;   end
                            1: begin whole = -2147; micro = -483648;  end
                            2: begin whole = 4095;  micro = 1048575;  end
                            default: begin whole = -4096; micro = -1048576; end
                        endcase
                    end
                    MODE_WORST_CASE: begin
                        // full scale with the sign of each tap, so the sum peaks
                        if (WEIGHT_MILLIONTHS[i] == 0) begin
                            whole = 0;
                            micro = 0;
                        end else if ((WEIGHT_MILLIONTHS[i] > 0) != neg) begin
                            whole = 2147;
                            micro = 483647;
                        end else begin
                            whole = -2147;
                            micro = -483648;
                        end
                    end
                    default: begin
                        whole = 0;
                        micro = int'($urandom_range(0, 4000)) - 2000;
                    end
                endcase
                send_reading(whole, micro);
                sent++;
            end
        end
        wait_for_results();
    endtask

    // receiver holds off while readings keep coming, so the input stalls
    task automatic test_output_backpressure();
        release_input();
        hold_request = hold_request + 1;
        @(posedge i_clk);
        for (int i = 0; i < 6; i++) begin
            send_reading(int'($urandom_range(0, 4294)) - 2147,
                         int'($urandom_range(0, 1999998)) - 999999);
        end
        wait_for_results();
    endtask

    // sender stops until all results are back, then resumes
    task automatic test_drain_pause();
        for (int r = 0; r < 2; r++) begin
            for (int i = 0; i < 10; i++) begin
                send_reading(int'($urandom_range(0, 4294)) - 2147,
                             int'($urandom_range(0, 1999998)) - 999999);
            end
            wait_for_results();
        end
    endtask

    // receiver: random ready while idling is on, else always ready, with a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_request != hold_taken) begin
            hold_taken = hold_request;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left    = hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (idling_on) begin
            out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_output
        t_split_reading exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (filtered_q.size() == 0) begin
                $error("result with no reading pending: %0d / %0d",
                       out_if.out_integer_part, out_if.out_micro_part);
                err_count++;
            end else begin
                exp_r = filtered_q.pop_front();
                if (out_if.out_integer_part !== exp_r.whole) begin
                    $error("out_integer_part: expected %0d, got %0d",
                           exp_r.whole, out_if.out_integer_part);
                    err_count++;
                end
                if (out_if.out_micro_part !== exp_r.micro) begin
                    $error("out_micro_part: expected %0d, got %0d",
                           exp_r.micro, out_if.out_micro_part);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results pending",
                   cycle_count, filtered_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // reset, then the tests in turn
    initial begin
        in_if.valid        = 1'b0;
        in_if.integer_part = '0;
        in_if.micro_part   = '0;
        out_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        for (int k = 0; k < TAPS; k++) begin
            tap_coef[k]    = fixed_weight(WEIGHT_MILLIONTHS[k]);
            sample_hist[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_readings();
        test_random_readings();
        test_output_backpressure();
        test_drain_pause();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && filtered_q.size() == 0) begin
            $display("PASS");
        end else begin
            if (filtered_q.size() != 0) begin
                $error("%0d expected results never arrived", filtered_q.size());
            end
            $display("FAIL");
        end
        $finish;
    end

endmodule
